### rtl/core/jsc_pkg.sv
// Package with the types, character codes and token functions of the JSON syntax checker.
`timescale 1ns / 1ps
`default_nettype none

package jsc_pkg;

    localparam int MAX_DEPTH   = 64;
    localparam int DEPTH_W     = $clog2(MAX_DEPTH + 1);
    localparam int ADDR_W      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int STATUS_W    = 3;
    localparam int OUT_DEPTH_W = 7;
    localparam int WORD_W      = 6;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_LBRACK = 8'h5b;
    localparam logic [7:0] CH_RBRACK = 8'h5d;
    localparam logic [7:0] CH_LBRACE = 8'h7b;
    localparam logic [7:0] CH_RBRACE = 8'h7d;
    localparam logic [7:0] CH_COMMA  = 8'h2c;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7a;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6e;

    localparam logic [1:0] WORD_NONE  = 2'd0;
    localparam logic [1:0] WORD_TRUE  = 2'd1;
    localparam logic [1:0] WORD_FALSE = 2'd2;
    localparam logic [1:0] WORD_NULL  = 2'd3;

    typedef enum logic [3:0] {
        LX_BETWEEN = 4'd0,
        LX_STR     = 4'd1,
        LX_ESC     = 4'd2,
        LX_MINUS   = 4'd3,
        LX_INT     = 4'd4,
        LX_ZERO    = 4'd5,
        LX_DOT     = 4'd6,
        LX_FRAC    = 4'd7,
        LX_WORD    = 4'd8
    } lx_state_t;

    typedef enum logic [2:0] {
        GR_TOP       = 3'd0,
        GR_ARR_FIRST = 3'd1,
        GR_VALUE     = 3'd2,
        GR_OBJ_FIRST = 3'd3,
        GR_KEY       = 3'd4,
        GR_COLON     = 3'd5,
        GR_AFTER     = 3'd6,
        GR_DONE      = 3'd7
    } gr_state_t;

    typedef enum logic [3:0] {
        TK_STRING    = 4'd0,
        TK_SCALAR    = 4'd1,
        TK_OPEN_ARR  = 4'd2,
        TK_OPEN_OBJ  = 4'd3,
        TK_CLOSE_ARR = 4'd4,
        TK_CLOSE_OBJ = 4'd5,
        TK_COMMA     = 4'd6,
        TK_COLON     = 4'd7,
        TK_PAREN     = 4'd8
    } token_t;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_LEXICAL  = 3'd1,
        ERR_SYNTAX   = 3'd2,
        ERR_BAD_WORD = 3'd3,
        ERR_EARLY    = 3'd4,
        ERR_TRAILING = 3'd5,
        ERR_DEPTH    = 3'd6
    } err_t;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_PUSH = 2'd1,
        OP_POP  = 2'd2
    } stack_op_t;

    typedef struct packed {
        gr_state_t gs;
        err_t      err;
        stack_op_t op;
        logic      obj;
    } gr_result_t;

    typedef struct packed {
        lx_state_t         ls;
        logic [WORD_W-1:0] wm;
        logic              tk_valid;
        token_t            tk;
        err_t              err;
    } lx_start_t;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [2:0] word_len(logic [1:0] id);
        case (id)
            WORD_TRUE:  return 3'd4;
            WORD_FALSE: return 3'd5;
            WORD_NULL:  return 3'd4;
            default:    return 3'd0;
        endcase
    endfunction

    function automatic logic [7:0] word_char(logic [1:0] id, logic [2:0] n);
        logic [39:0] text;
        text = 40'h0;
        case (id)
            WORD_TRUE:  text = 40'h0065757274;
            WORD_FALSE: text = 40'h65736c6166;
            WORD_NULL:  text = 40'h006c6c756e;
            default:    text = 40'h0;
        endcase
        case (n)
            3'd0:    return text[7:0];
            3'd1:    return text[15:8];
            3'd2:    return text[23:16];
            3'd3:    return text[31:24];
            3'd4:    return text[39:32];
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] word_step(logic [WORD_W-1:0] wm, logic [7:0] c);
        logic [1:0] id;
        logic [2:0] n;
        id = wm[4:3];
        n  = wm[2:0];
        if ((id != WORD_NONE) && (n < word_len(id)) && (word_char(id, n) == c))
            return {1'b0, id, 3'(n + 3'd1)};
        return '0;
    endfunction

    function automatic logic word_done(logic [WORD_W-1:0] wm);
        return (wm[4:3] != WORD_NONE) && (wm[2:0] == word_len(wm[4:3]));
    endfunction

    function automatic lx_start_t lex_start(logic [7:0] c);
        lx_start_t r;
        r.ls       = LX_BETWEEN;
        r.wm       = '0;
        r.tk_valid = 1'b0;
        r.tk       = TK_STRING;
        r.err      = ERR_NONE;
        if (is_space(c)) begin
            r.ls = LX_BETWEEN;
        end else if (c == CH_QUOTE) begin
            r.ls = LX_STR;
        end else if (c == CH_MINUS) begin
            r.ls = LX_MINUS;
        end else if (c == CH_ZERO) begin
            r.ls = LX_ZERO;
        end else if (is_digit(c)) begin
            r.ls = LX_INT;
        end else if (is_alpha(c)) begin
            r.ls = LX_WORD;
            if (c == CH_LOW_T)
                r.wm = {1'b0, WORD_TRUE, 3'd1};
            else if (c == CH_LOW_F)
                r.wm = {1'b0, WORD_FALSE, 3'd1};
            else if (c == CH_LOW_N)
                r.wm = {1'b0, WORD_NULL, 3'd1};
        end else begin
            r.tk_valid = 1'b1;
            case (c)
                CH_LBRACK: r.tk = TK_OPEN_ARR;
                CH_RBRACK: r.tk = TK_CLOSE_ARR;
                CH_LBRACE: r.tk = TK_OPEN_OBJ;
                CH_RBRACE: r.tk = TK_CLOSE_OBJ;
                CH_COMMA:  r.tk = TK_COMMA;
                CH_COLON:  r.tk = TK_COLON;
                CH_LPAREN: r.tk = TK_PAREN;
                CH_RPAREN: r.tk = TK_PAREN;
                default:
                begin
                    r.tk_valid = 1'b0;
                    r.err      = ERR_LEXICAL;
                end
            endcase
        end
        return r;
    endfunction

    function automatic gr_result_t gr_step(gr_state_t gs, token_t tk,
                                           logic [DEPTH_W-1:0] depth, logic top_obj);
        gr_result_t r;
        logic       is_open;
        logic       is_obj;
        logic       do_close;
        logic       obj_top;
        r.gs     = gs;
        r.err    = ERR_NONE;
        r.op     = OP_NONE;
        r.obj    = 1'b0;
        is_open  = 1'b0;
        do_close = 1'b0;
        is_obj   = (tk == TK_OPEN_OBJ);
        obj_top  = (depth != '0) && top_obj;
        case (gs)
            GR_TOP:
            begin
                if ((tk == TK_OPEN_ARR) || (tk == TK_OPEN_OBJ))
                    is_open = 1'b1;
                else
                    r.err = ERR_SYNTAX;
            end
            GR_ARR_FIRST, GR_VALUE:
            begin
                if ((gs == GR_ARR_FIRST) && (tk == TK_CLOSE_ARR))
                    do_close = 1'b1;
                else if ((tk == TK_STRING) || (tk == TK_SCALAR))
                    r.gs = GR_AFTER;
                else if ((tk == TK_OPEN_ARR) || (tk == TK_OPEN_OBJ))
                    is_open = 1'b1;
                else
                    r.err = ERR_SYNTAX;
            end
            GR_OBJ_FIRST, GR_KEY:
            begin
                if ((gs == GR_OBJ_FIRST) && (tk == TK_CLOSE_OBJ))
                    do_close = 1'b1;
                else if (tk == TK_STRING)
                    r.gs = GR_COLON;
                else
                    r.err = ERR_SYNTAX;
            end
            GR_COLON:
            begin
                if (tk == TK_COLON)
                    r.gs = GR_VALUE;
                else
                    r.err = ERR_SYNTAX;
            end
            GR_AFTER:
            begin
                if (tk == TK_COMMA)
                    r.gs = obj_top ? GR_KEY : GR_VALUE;
                else if (((tk == TK_CLOSE_ARR) && !obj_top) || ((tk == TK_CLOSE_OBJ) && obj_top))
                    do_close = 1'b1;
                else
                    r.err = ERR_SYNTAX;
            end
            default:
            begin
                r.err = ERR_TRAILING;
            end
        endcase
        if (is_open) begin
            if (depth >= DEPTH_W'(MAX_DEPTH)) begin
                r.err = ERR_DEPTH;
            end else begin
                r.op  = OP_PUSH;
                r.obj = is_obj;
                r.gs  = is_obj ? GR_OBJ_FIRST : GR_ARR_FIRST;
            end
        end
        if (do_close) begin
            if (depth != '0)
                r.op = OP_POP;
            r.gs = (depth <= DEPTH_W'(1)) ? GR_DONE : GR_AFTER;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/core/json_syntax_checker_depth.sv
// Top level of the streaming JSON syntax checker with nesting depth tracking.
//
//   channel   direction  handshake           payload
//   input     in         in_valid/in_stall   next_byte[7:0], end_of_doc
//   output    out        out_valid/out_stall status[2:0], max_depth[6:0]
//
// One byte is taken every cycle unless the output register is stalled, and an
// input transaction is never held longer than that stall. The lexer, grammar
// and stack top are settled combinationally; the container stack lives in a RAM
// whose read port always fetches the level below the top, so a close never waits.
// Reset clears all control state; the stack RAM needs no clearing.
// Only the end-of-document transaction yields a result, in the cycle after it is taken.
`timescale 1ns / 1ps
`default_nettype none

module json_syntax_checker_depth
    import jsc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [7:0]             next_byte,
    input  wire logic                   end_of_doc,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [STATUS_W-1:0]         status,
    output logic [OUT_DEPTH_W-1:0]      max_depth
);

    lx_state_t            ls_reg, ls_next;
    logic [WORD_W-1:0]    wm_reg, wm_next;
    gr_state_t            gs_reg, gs_next;
    err_t                 err_reg, err_next;
    logic [DEPTH_W-1:0]   depth_reg, depth_next;
    logic [DEPTH_W-1:0]   deepest_reg, deepest_next;
    logic                 top_reg, top_next;
    logic                 out_valid_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [OUT_DEPTH_W-1:0] max_depth_reg;

    logic                 accept;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ADDR_W-1:0]    ram_raddr;
    logic                 ram_rdata;
    logic [DEPTH_W-1:0]   raddr_full;

    lx_state_t            lx;
    logic [WORD_W-1:0]    wm;
    gr_state_t            gs;
    err_t                 err;
    err_t                 fin_err;
    stack_op_t            op;
    logic                 push_obj;
    logic                 restart;
    logic                 restart_word;
    logic                 start;
    logic                 tk2_valid;
    token_t               tk2;
    gr_result_t           r1;
    gr_result_t           r2;
    gr_result_t           rf;
    lx_start_t            s;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign max_depth = max_depth_reg;

    always_comb
    begin
        lx           = ls_reg;
        wm           = wm_reg;
        gs           = gs_reg;
        err          = err_reg;
        op           = OP_NONE;
        push_obj     = 1'b0;
        restart      = 1'b0;
        restart_word = 1'b0;
        start        = 1'b0;
        tk2_valid    = 1'b0;
        tk2          = TK_STRING;
        r1           = '0;
        r2           = '0;
        s            = '0;

        case (ls_reg)
            LX_STR:
            begin
                if (next_byte == CH_BSLASH) begin
                    lx = LX_ESC;
                end else if (next_byte == CH_QUOTE) begin
                    lx        = LX_BETWEEN;
                    tk2_valid = 1'b1;
                    tk2       = TK_STRING;
                end
            end
            LX_ESC:
            begin
                if ((next_byte == CH_QUOTE) || (next_byte == CH_BSLASH))
                    lx = LX_STR;
                else
                    err = ERR_LEXICAL;
            end
            LX_MINUS:
            begin
                if (next_byte == CH_ZERO)
                    lx = LX_ZERO;
                else if (is_digit(next_byte))
                    lx = LX_INT;
                else
                    err = ERR_LEXICAL;
            end
            LX_INT:
            begin
                if (next_byte == CH_DOT)
                    lx = LX_DOT;
                else if (!is_digit(next_byte))
                    restart = 1'b1;
            end
            LX_ZERO:
            begin
                if (next_byte == CH_DOT)
                    lx = LX_DOT;
                else
                    restart = 1'b1;
            end
            LX_DOT:
            begin
                if (is_digit(next_byte))
                    lx = LX_FRAC;
                else
                    err = ERR_LEXICAL;
            end
            LX_FRAC:
            begin
                if (!is_digit(next_byte))
                    restart = 1'b1;
            end
            LX_WORD:
            begin
                if (is_alpha(next_byte) || is_digit(next_byte) || (next_byte == CH_UNDER)) begin
                    wm = word_step(wm_reg, next_byte);
                end else begin
                    restart      = 1'b1;
                    restart_word = 1'b1;
                end
            end
            default:
            begin
                start = 1'b1;
            end
        endcase

        if (restart) begin
            lx = LX_BETWEEN;
            if (restart_word && !word_done(wm_reg)) begin
                err = ERR_BAD_WORD;
            end else begin
                r1  = gr_step(gs_reg, TK_SCALAR, depth_reg, top_reg);
                gs  = r1.gs;
                err = r1.err;
            end
            start = (err == ERR_NONE);
        end

        if (start) begin
            s   = lex_start(next_byte);
            lx  = s.ls;
            err = s.err;
            if (s.ls == LX_WORD)
                wm = s.wm;
            tk2_valid = s.tk_valid;
            tk2       = s.tk;
        end

        if (tk2_valid && (err == ERR_NONE)) begin
            r2       = gr_step(gs, tk2, depth_reg, top_reg);
            gs       = r2.gs;
            err      = r2.err;
            op       = r2.op;
            push_obj = r2.obj;
        end
    end

    always_comb
    begin
        rf      = '0;
        fin_err = err_reg;
        if (err_reg == ERR_NONE) begin
            rf.gs = gs_reg;
            case (ls_reg)
                LX_INT, LX_ZERO, LX_FRAC:
                begin
                    rf      = gr_step(gs_reg, TK_SCALAR, depth_reg, top_reg);
                    fin_err = rf.err;
                end
                LX_WORD:
                begin
                    if (word_done(wm_reg)) begin
                        rf      = gr_step(gs_reg, TK_SCALAR, depth_reg, top_reg);
                        fin_err = rf.err;
                    end else begin
                        fin_err = ERR_BAD_WORD;
                    end
                end
                LX_BETWEEN:
                begin
                    fin_err = ERR_NONE;
                end
                default:
                begin
                    fin_err = ERR_LEXICAL;
                end
            endcase
            if ((fin_err == ERR_NONE) && (rf.gs != GR_DONE))
                fin_err = ERR_EARLY;
        end
    end

    always_comb
    begin
        ls_next      = ls_reg;
        wm_next      = wm_reg;
        gs_next      = gs_reg;
        err_next     = err_reg;
        depth_next   = depth_reg;
        deepest_next = deepest_reg;
        top_next     = top_reg;
        ram_we       = 1'b0;
        ram_waddr    = depth_reg[ADDR_W-1:0];
        if (accept) begin
            if (end_of_doc) begin
                ls_next      = LX_BETWEEN;
                wm_next      = '0;
                gs_next      = GR_TOP;
                err_next     = ERR_NONE;
                depth_next   = '0;
                deepest_next = '0;
                top_next     = 1'b0;
            end else if (err_reg == ERR_NONE) begin
                ls_next  = lx;
                wm_next  = wm;
                gs_next  = gs;
                err_next = err;
                case (op)
                    OP_PUSH:
                    begin
                        ram_we     = 1'b1;
                        depth_next = DEPTH_W'(depth_reg + DEPTH_W'(1));
                        top_next   = push_obj;
                        if (depth_next > deepest_reg)
                            deepest_next = depth_next;
                    end
                    OP_POP:
                    begin
                        depth_next = DEPTH_W'(depth_reg - DEPTH_W'(1));
                        top_next   = ram_rdata;
                    end
                    default:
                    begin
                        depth_next = depth_reg;
                    end
                endcase
            end
        end
    end

    // The read port fetches the level just below the new top for the next pop.
    assign raddr_full = DEPTH_W'(depth_next - DEPTH_W'(2));
    assign ram_raddr  = raddr_full[ADDR_W-1:0];

    jsc_ram #(
        .WIDTH(1),
        .DEPTH(MAX_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (push_obj),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ls_reg        <= LX_BETWEEN;
            wm_reg        <= '0;
            gs_reg        <= GR_TOP;
            err_reg       <= ERR_NONE;
            depth_reg     <= '0;
            deepest_reg   <= '0;
            top_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            ls_reg      <= ls_next;
            wm_reg      <= wm_next;
            gs_reg      <= gs_next;
            err_reg     <= err_next;
            depth_reg   <= depth_next;
            deepest_reg <= deepest_next;
            top_reg     <= top_next;
            if (accept && end_of_doc)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && end_of_doc) begin
            status_reg    <= STATUS_W'(fin_err);
            max_depth_reg <= OUT_DEPTH_W'(deepest_reg);
        end
    end

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(MAX_DEPTH))
        else $error("nesting depth beyond limit");

    a_deepest_covers: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= deepest_reg)
        else $error("deepest level below current depth");

    a_push_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (depth_reg < DEPTH_W'(MAX_DEPTH)) && (err_reg == ERR_NONE))
        else $error("stack write outside admitted levels");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_doc) |=> out_valid && (depth_reg == '0) && (err_reg == ERR_NONE))
        else $error("end transaction did not produce a verdict and clear state");

endmodule

`default_nettype wire

### rtl/core/jsc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none

module jsc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### tb/tb_json_syntax_checker_depth.sv
// Self-checking testbench for the streaming JSON syntax checker with nesting depth tracking.
`timescale 1ns / 1ps

module tb_json_syntax_checker_depth;
    import jsc_pkg::*;

    localparam int ITEMS_TARGET = 1350;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES  = 16;

    typedef struct {
        err_t             code;
        logic [6:0]       depth;
    } verdict_t;

    class verdict_board;
        verdict_t  pending_q[$];
        int        errors;
        int        seen[8];
        lx_state_t lex;
        logic [5:0] wmatch;
        gr_state_t gram;
        bit        kinds[MAX_DEPTH];
        int        level;
        int        peak;
        err_t      fault;
        string     word_txt[4] = '{"", "true", "false", "null"};

        function new();
            errors = 0;
            foreach (seen[i])
                seen[i] = 0;
            foreach (kinds[i])
                kinds[i] = 1'b0;
            clear_doc();
        endfunction

        function void clear_doc();
            lex    = LX_BETWEEN;
            wmatch = '0;
            gram   = GR_TOP;
            level  = 0;
            peak   = 0;
            fault  = ERR_NONE;
        endfunction

        function bit digit_char(logic [7:0] c);
            return (c >= CH_ZERO) && (c <= CH_NINE);
        endfunction

        function bit letter_char(logic [7:0] c);
            return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
        endfunction

        function bit blank_char(logic [7:0] c);
            return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        endfunction

        function void fail_with(err_t code);
            if (fault == ERR_NONE)
                fault = code;
        endfunction

        function void open_container(bit is_obj);
            if (level >= MAX_DEPTH) begin
                fail_with(ERR_DEPTH);
                return;
            end
            kinds[level] = is_obj;
            level++;
            if (level > peak)
                peak = level;
            if (is_obj)
                gram = GR_OBJ_FIRST;
            else
                gram = GR_ARR_FIRST;
        endfunction

        function void close_container();
            if (level > 0)
                level--;
            if (level == 0)
                gram = GR_DONE;
            else
                gram = GR_AFTER;
        endfunction

        function void accept_value(token_t tk);
            if ((tk == TK_STRING) || (tk == TK_SCALAR))
                gram = GR_AFTER;
            else if ((tk == TK_OPEN_ARR) || (tk == TK_OPEN_OBJ))
                open_container(tk == TK_OPEN_OBJ);
            else
                fail_with(ERR_SYNTAX);
        endfunction

        function void feed_token(token_t tk);
            bit top_obj;
            case (gram)
                GR_TOP:
                begin
                    if ((tk == TK_OPEN_ARR) || (tk == TK_OPEN_OBJ))
                        open_container(tk == TK_OPEN_OBJ);
                    else
                        fail_with(ERR_SYNTAX);
                end
                GR_ARR_FIRST:
                begin
                    if (tk == TK_CLOSE_ARR)
                        close_container();
                    else
                        accept_value(tk);
                end
                GR_VALUE:
                begin
                    accept_value(tk);
                end
                GR_OBJ_FIRST:
                begin
                    if (tk == TK_CLOSE_OBJ)
                        close_container();
                    else if (tk == TK_STRING)
                        gram = GR_COLON;
                    else
                        fail_with(ERR_SYNTAX);
                end
                GR_KEY:
                begin
                    if (tk == TK_STRING)
                        gram = GR_COLON;
                    else
                        fail_with(ERR_SYNTAX);
                end
                GR_COLON:
                begin
                    if (tk == TK_COLON)
                        gram = GR_VALUE;
                    else
                        fail_with(ERR_SYNTAX);
                end
                GR_AFTER:
                begin
                    top_obj = (level > 0) ? kinds[level - 1] : 1'b0;
                    if (tk == TK_COMMA) begin
                        if (top_obj)
                            gram = GR_KEY;
                        else
                            gram = GR_VALUE;
                    end else if (((tk == TK_CLOSE_ARR) && !top_obj)
                                 || ((tk == TK_CLOSE_OBJ) && top_obj)) begin
                        close_container();
                    end else begin
                        fail_with(ERR_SYNTAX);
                    end
                end
                default:
                begin
                    fail_with(ERR_TRAILING);
                end
            endcase
        endfunction

        function void finish_word();
            logic [1:0] id;
            logic [2:0] n;
            id = wmatch[4:3];
            n  = wmatch[2:0];
            if ((id != WORD_NONE) && (n == word_txt[id].len()))
                feed_token(TK_SCALAR);
            else
                fail_with(ERR_BAD_WORD);
        endfunction

        function void start_token(logic [7:0] c);
            lex = LX_BETWEEN;
            if (blank_char(c))
                return;
            if (c == CH_QUOTE) begin
                lex = LX_STR;
            end else if (c == CH_MINUS) begin
                lex = LX_MINUS;
            end else if (c == CH_ZERO) begin
                lex = LX_ZERO;
            end else if (digit_char(c)) begin
                lex = LX_INT;
            end else if (letter_char(c)) begin
                lex = LX_WORD;
                if (c == CH_LOW_T)
                    wmatch = {1'b0, WORD_TRUE, 3'd1};
                else if (c == CH_LOW_F)
                    wmatch = {1'b0, WORD_FALSE, 3'd1};
                else if (c == CH_LOW_N)
                    wmatch = {1'b0, WORD_NULL, 3'd1};
                else
                    wmatch = '0;
            end else if (c == CH_LBRACK) begin
                feed_token(TK_OPEN_ARR);
            end else if (c == CH_RBRACK) begin
                feed_token(TK_CLOSE_ARR);
            end else if (c == CH_LBRACE) begin
                feed_token(TK_OPEN_OBJ);
            end else if (c == CH_RBRACE) begin
                feed_token(TK_CLOSE_OBJ);
            end else if (c == CH_COMMA) begin
                feed_token(TK_COMMA);
            end else if (c == CH_COLON) begin
                feed_token(TK_COLON);
            end else if ((c == CH_LPAREN) || (c == CH_RPAREN)) begin
                feed_token(TK_PAREN);
            end else begin
                fail_with(ERR_LEXICAL);
            end
        endfunction

        function void end_and_restart(logic [7:0] c, bit was_word);
            lex = LX_BETWEEN;
            if (was_word)
                finish_word();
            else
                feed_token(TK_SCALAR);
            if (fault == ERR_NONE)
                start_token(c);
        endfunction

        function void lex_char(logic [7:0] c);
            logic [1:0] id;
            logic [2:0] n;
            case (lex)
                LX_STR:
                begin
                    if (c == CH_BSLASH) begin
                        lex = LX_ESC;
                    end else if (c == CH_QUOTE) begin
                        lex = LX_BETWEEN;
                        feed_token(TK_STRING);
                    end
                end
                LX_ESC:
                begin
                    if ((c == CH_QUOTE) || (c == CH_BSLASH))
                        lex = LX_STR;
                    else
                        fail_with(ERR_LEXICAL);
                end
                LX_MINUS:
                begin
                    if (c == CH_ZERO)
                        lex = LX_ZERO;
                    else if (digit_char(c))
                        lex = LX_INT;
                    else
                        fail_with(ERR_LEXICAL);
                end
                LX_INT:
                begin
                    if (!digit_char(c)) begin
                        if (c == CH_DOT)
                            lex = LX_DOT;
                        else
                            end_and_restart(c, 1'b0);
                    end
                end
                LX_ZERO:
                begin
                    if (c == CH_DOT)
                        lex = LX_DOT;
                    else
                        end_and_restart(c, 1'b0);
                end
                LX_DOT:
                begin
                    if (digit_char(c))
                        lex = LX_FRAC;
                    else
                        fail_with(ERR_LEXICAL);
                end
                LX_FRAC:
                begin
                    if (!digit_char(c))
                        end_and_restart(c, 1'b0);
                end
                LX_WORD:
                begin
                    if (letter_char(c) || digit_char(c) || (c == CH_UNDER)) begin
                        id = wmatch[4:3];
                        n  = wmatch[2:0];
                        if ((id != WORD_NONE) && (n < word_txt[id].len())
                            && (word_txt[id][n] == c))
                            wmatch = {1'b0, id, 3'(n + 3'd1)};
                        else
                            wmatch = '0;
                    end else begin
                        end_and_restart(c, 1'b1);
                    end
                end
                default:
                begin
                    start_token(c);
                end
            endcase
        endfunction

        function void close_doc();
            if (fault != ERR_NONE)
                return;
            case (lex)
                LX_INT, LX_ZERO, LX_FRAC:
                begin
                    feed_token(TK_SCALAR);
                end
                LX_WORD:
                begin
                    finish_word();
                end
                LX_BETWEEN:
                begin
                end
                default:
                begin
                    fail_with(ERR_LEXICAL);
                end
            endcase
            lex = LX_BETWEEN;
            if ((fault == ERR_NONE) && (gram != GR_DONE))
                fail_with(ERR_EARLY);
        endfunction

        function void note_item(logic [7:0] c, logic eod);
            verdict_t v;
            if (eod) begin
                close_doc();
                v.code  = fault;
                v.depth = 7'(peak);
                pending_q.push_back(v);
                clear_doc();
            end else if (fault == ERR_NONE) begin
                lex_char(c);
            end
        endfunction

        function void check_verdict(logic [2:0] st, logic [6:0] md);
            verdict_t v;
            if (pending_q.size() == 0) begin
                $error("result with no document pending: status %0d, max_depth %0d", st, md);
                errors++;
                return;
            end
            v = pending_q.pop_front();
            seen[v.code]++;
            if (st !== v.code) begin
                $error("status mismatch: expected %0d, actual %0d", v.code, st);
                errors++;
            end
            if (md !== v.depth) begin
                $error("max_depth mismatch: expected %0d, actual %0d", v.depth, md);
                errors++;
            end
        endfunction
    endclass

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_stall;
    logic [7:0] next_byte  = 8'h00;
    logic       end_of_doc = 1'b0;
    logic       out_valid;
    logic       out_stall  = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [OUT_DEPTH_W-1:0] max_depth;

    verdict_board board;
    logic [7:0]   doc_q[$];
    int           send_idle_pct = 0;
    int           stall_pct     = 0;
    int           items_sent    = 0;
    int           docs_sent     = 0;

    json_syntax_checker_depth DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .next_byte  (next_byte),
        .end_of_doc (end_of_doc),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .max_depth  (max_depth)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_verdict(status, max_depth);
    end

    function automatic void put(logic [7:0] b);
        doc_q.push_back(b);
    endfunction

    function automatic void pad();
        if ($urandom_range(3) == 0) begin
            if ($urandom_range(1) == 0)
                put(CH_SPACE);
            else
                put(CH_TAB + 8'($urandom_range(4)));
        end
    endfunction

    function automatic void load_text(string s);
        doc_q.delete();
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endfunction

    function automatic void load_word(string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endfunction

    function automatic void gen_string();
        logic [7:0] b;
        put(CH_QUOTE);
        repeat ($urandom_range(4)) begin
            if ($urandom_range(7) == 0) begin
                put(CH_BSLASH);
                put(($urandom_range(1) == 0) ? CH_QUOTE : CH_BSLASH);
            end else begin
                b = 8'($urandom_range(255));
                if ((b == CH_QUOTE) || (b == CH_BSLASH))
                    b = CH_LOW_A;
                put(b);
            end
        end
        put(CH_QUOTE);
    endfunction

    function automatic void gen_number();
        if ($urandom_range(3) == 0)
            put(CH_MINUS);
        if ($urandom_range(2) == 0) begin
            put(CH_ZERO);
        end else begin
            put(CH_ZERO + 8'($urandom_range(1, 9)));
            repeat ($urandom_range(3))
                put(CH_ZERO + 8'($urandom_range(9)));
        end
        if ($urandom_range(2) == 0) begin
            put(CH_DOT);
            repeat ($urandom_range(1, 3))
                put(CH_ZERO + 8'($urandom_range(9)));
        end
    endfunction

    function automatic void gen_value(int budget);
        int pick;
        pick = $urandom_range(5);
        if ((budget > 0) && (pick < 2)) begin
            gen_container(budget - 1, pick[0]);
        end else if (pick < 3) begin
            gen_string();
        end else if (pick < 5) begin
            gen_number();
        end else begin
            case ($urandom_range(2))
                0:       load_word("true");
                1:       load_word("false");
                default: load_word("null");
            endcase
        end
    endfunction

    function automatic void gen_container(int budget, bit obj);
        int n;
        n = $urandom_range(3);
        put(obj ? CH_LBRACE : CH_LBRACK);
        pad();
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                put(CH_COMMA);
                pad();
            end
            if (obj) begin
                gen_string();
                pad();
                put(CH_COLON);
                pad();
            end
            gen_value(budget);
            pad();
        end
        put(obj ? CH_RBRACE : CH_RBRACK);
    endfunction

    function automatic void gen_deep(int n);
        bit kinds_q[$];
        doc_q.delete();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(7) == 0) begin
                load_word("{\"k\":");
                kinds_q.push_back(1'b1);
            end else begin
                put(CH_LBRACK);
                kinds_q.push_back(1'b0);
            end
        end
        put(CH_ZERO + 8'($urandom_range(1, 9)));
        for (int i = n - 1; i >= 0; i--)
            put(kinds_q[i] ? CH_RBRACE : CH_RBRACK);
    endfunction

    function automatic void mutate_doc();
        logic [7:0] tricky[16] = '{CH_LPAREN, CH_RPAREN, CH_MINUS, CH_DOT, CH_ZERO, CH_BSLASH,
                                   CH_QUOTE, 8'h78, CH_UNDER, CH_COMMA, CH_COLON, CH_RBRACE,
                                   CH_RBRACK, CH_LBRACE, CH_LBRACK, 8'hff};
        int pos;
        pos = $urandom_range(doc_q.size() - 1);
        case ($urandom_range(4))
            0:
            begin
                doc_q[pos] = 8'($urandom_range(255));
            end
            1:
            begin
                doc_q.insert(pos, tricky[$urandom_range(15)]);
            end
            2:
            begin
                while (doc_q.size() > pos)
                    doc_q.delete(doc_q.size() - 1);
            end
            3:
            begin
                pad();
                case ($urandom_range(3))
                    0:       put(CH_ZERO + 8'($urandom_range(9)));
                    1:       put(CH_LBRACK);
                    2:       load_word("tru");
                    default: put(CH_LPAREN);
                endcase
            end
            default:
            begin
                doc_q.insert(pos, CH_BSLASH);
                doc_q.insert(pos + 1, 8'($urandom_range(255)));
            end
        endcase
    endfunction

    task automatic drive_item(logic [7:0] b, logic eod);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        next_byte  <= b;
        end_of_doc <= eod;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_item(b, eod);
        items_sent++;
    endtask

    task automatic send_doc();
        foreach (doc_q[i])
            drive_item(doc_q[i], 1'b0);
        drive_item(8'($urandom_range(255)), 1'b1);
        docs_sent++;
    endtask

    task automatic set_phase(int idx);
        case (idx)
            0:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            1:
            begin
                send_idle_pct = 71;
                stall_pct     = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct     = 71;
            end
            default:
            begin
                send_idle_pct = 17;
                stall_pct     = 17;
            end
        endcase
    endtask

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        int pick;
        int rand_docs;
        board = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_phase(3);
        load_text("");
        send_doc();
        load_text("[01]");
        send_doc();
        load_text("[-");
        send_doc();
        load_text("[1.");
        send_doc();
        load_text("[\"\\");
        send_doc();
        load_text("[]1");
        send_doc();
        load_text("[nu]");
        send_doc();
        load_text("[(");
        send_doc();
        load_text("[");
        put(8'hff);
        send_doc();

        rand_docs = 0;
        while (items_sent < ITEMS_TARGET) begin
            set_phase(((items_sent * 8) / ITEMS_TARGET) % 4);
            if (rand_docs == 7) begin
                gen_deep(MAX_DEPTH);
            end else if (rand_docs == 23) begin
                gen_deep(MAX_DEPTH + 1);
            end else if (rand_docs == 41) begin
                gen_deep($urandom_range(MAX_DEPTH - 6, MAX_DEPTH + 2));
            end else begin
                pick = $urandom_range(99);
                doc_q.delete();
                if (pick < 88) begin
                    gen_container($urandom_range(3), $urandom_range(1));
                    if (pick >= 55)
                        mutate_doc();
                end else begin
                    if ($urandom_range(1) == 0)
                        put(CH_LBRACK);
                    repeat ($urandom_range(1, 12))
                        put(8'($urandom_range(255)));
                end
            end
            send_doc();
            rand_docs++;
        end
        in_valid <= 1'b0;

        while (board.pending_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d documents in %0d byte and end transactions under four idle mixes.",
                 docs_sent, items_sent);
        $display("Verdicts: ok %0d, lexical %0d, syntax %0d, word %0d,",
                 board.seen[0], board.seen[1], board.seen[2], board.seen[3]);
        $display("          early %0d, trailing %0d, depth %0d.",
                 board.seen[4], board.seen[5], board.seen[6]);
        if (board.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
